### hdl/pws_pkg.sv
// Shared types and constants for the perspective world-to-screen pipeline.
`timescale 1ns / 1ps
package pws_pkg;

  // Config register indexes
  localparam logic [2:0] REG_X_COEFFS      = 3'd0;
  localparam logic [2:0] REG_Y_COEFFS      = 3'd1;
  localparam logic [2:0] REG_Z_COEFFS      = 3'd2;
  localparam logic [2:0] REG_OFFSET_XY     = 3'd3;
  localparam logic [2:0] REG_OFFSET_ZW     = 3'd4;
  localparam logic [2:0] REG_VIEW_W        = 3'd5;
  localparam logic [2:0] REG_VIEW_H        = 3'd6;

  localparam logic [63:0] RST_X_COEFFS      = 64'h0000_0000_0000_1000;
  localparam logic [63:0] RST_Y_COEFFS      = 64'h0000_0000_1000_0000;
  localparam logic [63:0] RST_Z_COEFFS      = 64'h0000_1000_0000_0000;
  localparam logic [63:0] RST_OFFSET_XY     = 64'h0;
  localparam logic [63:0] RST_OFFSET_ZW     = 64'h0001_0000_0000_0000;
  localparam logic [12:0] RST_VIEW_W        = 13'd1920;
  localparam logic [12:0] RST_VIEW_H        = 13'd1080;

  localparam int SW   = 13;         // viewport size width
  localparam int CW   = 51;         // clip value, Q.28
  localparam int W16W = CW - 12;    // clip value, Q16.16
  localparam int NUMW = W16W + 1;   // w16 +/- x16
  localparam int PW   = NUMW + SW + 1;
  localparam int NW   = 58;         // dividend
  localparam int DW   = W16W + 1;   // divisor 2*w16
  localparam int QW   = 21;         // quotient magnitude bits
  localparam int OW   = 20;         // output coordinate

  localparam logic signed [CW+3:0] THRESH_Q28 = (CW+4)'(268435456);
  localparam logic signed [OW-1:0] OUT_MAX    = 20'sd524287;
  localparam logic signed [OW-1:0] OUT_MIN    = -20'sd524288;
  localparam logic signed [OW-1:0] HIDDEN_Q4  = -20'sd16;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } in_word_t;

  typedef struct packed {
    logic              visible;
    logic signed [OW-1:0] screen_x;
    logic signed [OW-1:0] screen_y;
  } out_word_t;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [DW-1:0] den;
    logic [QW-1:0] quo;
    logic          neg;
    logic          ovf;
  } div_lane_t;

  // lane 0 is x, lane 1 is y
  typedef struct packed {
    logic               vis;
    div_lane_t [1:0]    lane;
  } div_word_t;

endpackage

### hdl/pws_clip.sv
// Matrix product stages: world point times view-projection columns x, y, w, plus offsets.
`timescale 1ns / 1ps
module pws_clip (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  pws_pkg::in_word_t     in_data,
  input  logic [63:0]           x_coeffs,
  input  logic [63:0]           y_coeffs,
  input  logic [63:0]           z_coeffs,
  input  logic [63:0]           offset_xy,
  input  logic [63:0]           offset_zw,
  output logic                  clip_valid,
  output logic signed [pws_pkg::CW-1:0] clip_x,
  output logic signed [pws_pkg::CW-1:0] clip_y,
  output logic signed [pws_pkg::CW-1:0] clip_w
);
  import pws_pkg::*;

  localparam int COL [3] = '{0, 1, 3};

  logic [63:0]        rows [3];
  logic signed [31:0] wv   [3];
  logic signed [31:0] off  [3];

  logic signed [47:0]   prod  [3][3];
  logic signed [CW-1:0] sum_a [3];
  logic signed [CW-1:0] sum_b [3];
  logic signed [CW-1:0] clip  [3];
  logic                 v1, v2, v3;

  always_comb begin
    rows[0] = x_coeffs;
    rows[1] = y_coeffs;
    rows[2] = z_coeffs;
    wv[0]   = in_data.world_x;
    wv[1]   = in_data.world_y;
    wv[2]   = in_data.world_z;
    off[0]  = $signed(offset_xy[31:0]);
    off[1]  = $signed(offset_xy[63:32]);
    off[2]  = $signed(offset_zw[63:32]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          prod[c][r] <= wv[r] * $signed(rows[r][16*COL[c] +: 16]);
        end
        sum_a[c] <= CW'(prod[c][0]) + CW'(prod[c][1]);
        sum_b[c] <= CW'(prod[c][2]) + (CW'(off[c]) <<< 12);
        clip[c]  <= sum_a[c] + sum_b[c];
      end
    end
  end

  assign clip_valid = v3;
  assign clip_x     = clip[0];
  assign clip_y     = clip[1];
  assign clip_w     = clip[2];

endmodule

### hdl/pws_prep.sv
// Visibility test and dividend/divisor setup for the two viewport axes.
`timescale 1ns / 1ps
module pws_prep (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  clip_valid,
  input  logic signed [pws_pkg::CW-1:0] clip_x,
  input  logic signed [pws_pkg::CW-1:0] clip_y,
  input  logic signed [pws_pkg::CW-1:0] clip_w,
  input  logic [pws_pkg::SW-1:0] view_w,
  input  logic [pws_pkg::SW-1:0] view_h,
  output logic                  div_valid,
  output pws_pkg::div_word_t    div_data
);
  import pws_pkg::*;

  logic signed [CW+3:0]   ten_w;
  logic signed [W16W-1:0] x16, y16, w16_c;

  logic                   v1, v2, v3, v4;
  logic                   vis1, vis2, vis3;
  logic signed [W16W-1:0] w16_1, w16_2;
  logic signed [NUMW-1:0] num1 [2];
  logic signed [PW-1:0]   prod2 [2];
  logic [SW-1:0]          size [2];
  logic signed [NW-1:0]   nn3 [2];
  logic [DW-1:0]          dd3;
  logic signed [NW:0]     mag [2];
  div_word_t              out_r;

  always_comb begin
    ten_w   = ((CW+4)'(clip_w) <<< 3) + ((CW+4)'(clip_w) <<< 1);
    x16     = clip_x[CW-1:12];
    y16     = clip_y[CW-1:12];
    w16_c   = clip_w[CW-1:12];
    size[0] = view_w;
    size[1] = view_h;
    for (int i = 0; i < 2; i++) begin
      // -N + D - 1 gives ceil magnitude so a floor quotient results
      mag[i] = -(NW+1)'(nn3[i]) + $signed({{(NW+1-DW){1'b0}}, dd3}) - (NW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= clip_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis1    <= (ten_w >= THRESH_Q28);
      w16_1   <= w16_c;
      num1[0] <= NUMW'(w16_c) + NUMW'(x16);
      num1[1] <= NUMW'(w16_c) - NUMW'(y16);

      vis2  <= vis1;
      w16_2 <= w16_1;
      for (int i = 0; i < 2; i++) begin
        prod2[i] <= $signed({1'b0, size[i]}) * num1[i];
      end

      vis3 <= vis2;
      dd3  <= {w16_2, 1'b0};
      for (int i = 0; i < 2; i++) begin
        nn3[i] <= (NW'(prod2[i]) <<< 4) + NW'(w16_2);
      end

      out_r.vis <= vis3;
      for (int i = 0; i < 2; i++) begin
        out_r.lane[i].neg <= nn3[i][NW-1];
        out_r.lane[i].den <= dd3;
        out_r.lane[i].quo <= '0;
        if (nn3[i][NW-1]) begin
          out_r.lane[i].rem <= mag[i][NW-1:0];
          out_r.lane[i].ovf <= (mag[i][NW-1:QW] >= (NW-QW)'(dd3));
        end else begin
          out_r.lane[i].rem <= nn3[i];
          out_r.lane[i].ovf <= (nn3[i][NW-1:QW] >= (NW-QW)'(dd3));
        end
      end
    end
  end

  assign div_valid = v4;
  assign div_data  = out_r;

endmodule

### hdl/pws_div_step.sv
// One restoring-division stage: settles quotient bit BIT on both lanes.
`timescale 1ns / 1ps
module pws_div_step #(
  parameter int BIT = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  pws_pkg::div_word_t in_data,
  output logic               out_valid,
  output pws_pkg::div_word_t out_data
);
  import pws_pkg::*;

  localparam int TW = DW + QW + 1;

  logic [TW-1:0] trial [2];
  div_word_t     nxt;

  always_comb begin
    nxt = in_data;
    for (int i = 0; i < 2; i++) begin
      trial[i] = TW'(in_data.lane[i].rem) - (TW'(in_data.lane[i].den) << BIT);
      if (!trial[i][TW-1]) begin
        nxt.lane[i].rem      = trial[i][NW-1:0];
        nxt.lane[i].quo[BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= nxt;
    end
  end

endmodule

### hdl/perspective_world_to_screen_unit.sv
// Top level: config registers, projection pipeline and output saturation.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  input   | in_valid, in_stall, in_data      | in
//  output  | out_valid, out_stall, out_data   | out
//  config  | wr_en, wr_index, wr_data         | in
//
// One word per cycle while the output is not stalled; stages in order:
// matrix product, setup, one stage per quotient bit, saturation.
// Synchronous reset clears all valid bits and loads the default matrix.
// A stalled output word freezes the whole pipeline; in_stall rises in the same cycle.
`timescale 1ns / 1ps
module perspective_world_to_screen_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pws_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pws_pkg::out_word_t  out_data,
  input  logic                wr_en,
  input  logic [2:0]          wr_index,
  input  logic [63:0]         wr_data
);
  import pws_pkg::*;

  logic [63:0]   x_coeffs, y_coeffs, z_coeffs, offset_xy, offset_zw;
  logic [SW-1:0] view_w, view_h;
  logic          en;

  logic                 clip_valid;
  logic signed [CW-1:0] clip_x, clip_y, clip_w;
  logic                 dv [QW+1];
  div_word_t            dw [QW+1];
  logic signed [OW-1:0] coord [2];
  out_word_t            out_next;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_coeffs  <= RST_X_COEFFS;
      y_coeffs  <= RST_Y_COEFFS;
      z_coeffs  <= RST_Z_COEFFS;
      offset_xy <= RST_OFFSET_XY;
      offset_zw <= RST_OFFSET_ZW;
      view_w    <= RST_VIEW_W;
      view_h    <= RST_VIEW_H;
    end else if (wr_en) begin
      case (wr_index)
        REG_X_COEFFS:  x_coeffs  <= wr_data;
        REG_Y_COEFFS:  y_coeffs  <= wr_data;
        REG_Z_COEFFS:  z_coeffs  <= wr_data;
        REG_OFFSET_XY: offset_xy <= wr_data;
        REG_OFFSET_ZW: offset_zw <= wr_data;
        REG_VIEW_W:    view_w    <= wr_data[SW-1:0];
        REG_VIEW_H:    view_h    <= wr_data[SW-1:0];
        default: ;
      endcase
    end
  end

  pws_clip u_clip (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .x_coeffs   (x_coeffs),
    .y_coeffs   (y_coeffs),
    .z_coeffs   (z_coeffs),
    .offset_xy  (offset_xy),
    .offset_zw  (offset_zw),
    .clip_valid (clip_valid),
    .clip_x     (clip_x),
    .clip_y     (clip_y),
    .clip_w     (clip_w)
  );

  pws_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .clip_valid (clip_valid),
    .clip_x     (clip_x),
    .clip_y     (clip_y),
    .clip_w     (clip_w),
    .view_w     (view_w),
    .view_h     (view_h),
    .div_valid  (dv[0]),
    .div_data   (dw[0])
  );

  for (genvar s = 0; s < QW; s++) begin : g_div
    pws_div_step #(.BIT(QW - 1 - s)) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dv[s]),
      .in_data   (dw[s]),
      .out_valid (dv[s+1]),
      .out_data  (dw[s+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (dw[QW].lane[i].neg) begin
        if (dw[QW].lane[i].ovf || (dw[QW].lane[i].quo > QW'(524288))) begin
          coord[i] = OUT_MIN;
        end else begin
          coord[i] = -$signed(dw[QW].lane[i].quo[OW-1:0]);
        end
      end else begin
        if (dw[QW].lane[i].ovf || (dw[QW].lane[i].quo > QW'(OUT_MAX))) begin
          coord[i] = OUT_MAX;
        end else begin
          coord[i] = $signed(dw[QW].lane[i].quo[OW-1:0]);
        end
      end
    end
    out_next.visible  = dw[QW].vis;
    out_next.screen_x = dw[QW].vis ? coord[0] : HIDDEN_Q4;
    out_next.screen_y = dw[QW].vis ? coord[1] : HIDDEN_Q4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
    end
  end

endmodule

### verif/tb.sv
// Testbench for the perspective world-to-screen unit: directed and random points.
`timescale 1ns / 1ps
module tb;
  import pws_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [63:0] wr_data = '0;

  logic [63:0] proj_regs [0:6];
  out_word_t pending_words [$];
  int mismatches = 0;
  int cycles = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;

  perspective_world_to_screen_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always #1 clk = ~clk;

  function automatic longint floor_quot(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic longint coeff(int row, int col);
    logic signed [15:0] c;
    c = proj_regs[row][16*col +: 16];
    return longint'(c);
  endfunction

  function automatic logic signed [19:0] to_pixel(longint size, longint num16, longint w16);
    longint v;
    v = floor_quot(16 * size * num16 + w16, 2 * w16);
    if (v > 524287) v = 524287;
    if (v < -524288) v = -524288;
    return v[19:0];
  endfunction

  function automatic out_word_t project_point(in_word_t p);
    longint wx, wy, wz, cx, cy, cw;
    logic signed [31:0] ox, oy, ow;
    out_word_t r;
    wx = longint'(p.world_x);
    wy = longint'(p.world_y);
    wz = longint'(p.world_z);
    ox = proj_regs[REG_OFFSET_XY][31:0];
    oy = proj_regs[REG_OFFSET_XY][63:32];
    ow = proj_regs[REG_OFFSET_ZW][63:32];
    cx = wx * coeff(0, 0) + wy * coeff(1, 0) + wz * coeff(2, 0) + longint'(ox) * 4096;
    cy = wx * coeff(0, 1) + wy * coeff(1, 1) + wz * coeff(2, 1) + longint'(oy) * 4096;
    cw = wx * coeff(0, 3) + wy * coeff(1, 3) + wz * coeff(2, 3) + longint'(ow) * 4096;
    if (10 * cw < 268435456) begin
      r.visible = 1'b0;
      r.screen_x = HIDDEN_Q4;
      r.screen_y = HIDDEN_Q4;
    end else begin
      longint x16, y16, w16;
      x16 = floor_quot(cx, 4096);
      y16 = floor_quot(cy, 4096);
      w16 = floor_quot(cw, 4096);
      r.visible = 1'b1;
      r.screen_x = to_pixel(longint'(proj_regs[REG_VIEW_W][12:0]), w16 + x16, w16);
      r.screen_y = to_pixel(longint'(proj_regs[REG_VIEW_H][12:0]), w16 - y16, w16);
    end
    return r;
  endfunction

  task automatic wait_idle();
    // drop valid so the last point is not taken again
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx <= REG_VIEW_H)
      proj_regs[idx] = (idx >= REG_VIEW_W) ? (val & 64'h1FFF) : val;
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {x, y, z};
    do @(posedge clk); while (in_stall);
    pending_words.push_back(project_point({x, y, z}));
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
      2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      default: return 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic logic [15:0] rand_q412();
    return 16'($signed($urandom_range(0, 16384)) - 8192);
  endfunction

  task automatic load_config(logic [63:0] mx, logic [63:0] my, logic [63:0] mz,
                             logic [63:0] oxy, logic [63:0] ozw, logic [12:0] w, logic [12:0] h);
    wait_idle();
    write_reg(REG_X_COEFFS, mx);
    write_reg(REG_Y_COEFFS, my);
    write_reg(REG_Z_COEFFS, mz);
    write_reg(REG_OFFSET_XY, oxy);
    write_reg(REG_OFFSET_ZW, ozw);
    write_reg(REG_VIEW_W, {51'd0, w});
    write_reg(REG_VIEW_H, {51'd0, h});
  endtask

  task automatic test_reset_defaults();
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_near_plane();
    // z steps across the 0.1 plane, but this matrix gives w no z term, so w stays zero
    load_config(64'h1000, 64'h1000_0000, 64'h1000_0000_0000, 64'h0, 64'h0, 13'd1920, 13'd1080);
    // unknown index must leave the matrix alone
    write_reg(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    send_point(32'h0, 32'h0, 32'd6553);
    send_point(32'h0, 32'h0, 32'd6554);
    send_point(32'h0001_0000, 32'h0001_0000, 32'd6554);
    send_point(32'h0, 32'h0, 32'h8000_0000);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
  endtask

  task automatic test_viewport_extremes();
    load_config(64'h1000, 64'h1000_0000, 64'h1000_0000_0000, 64'h0,
                64'h0001_0000_0000_0000, 13'd0, 13'd0);
    send_point(32'h0000_8000, 32'h0000_8000, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    load_config(64'h1000, 64'h1000_0000, 64'h1000_0000_0000, 64'hFFFF_0000_0001_0000,
                64'h0001_0000_0000_0000, 13'd8191, 13'd8191);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h0);
    load_config(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000, 64'h7FFF_8000_7FFF_8000,
                64'h7FFF_FFFF_8000_0000, 64'h7FFF_FFFF_8000_0000, 13'd1, 13'd4096);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_random_phase(bit camera, int n);
    logic [63:0] m [0:2];
    logic [12:0] w, h;
    for (int r = 0; r < 3; r++)
      m[r] = camera ? {rand_q412(), 16'h0, rand_q412(), rand_q412()} : {$urandom, $urandom};
    if (camera) m[2][63:48] = 16'($urandom_range(2048, 8192));
    w = $urandom_range(0, 3) == 0 ? 13'($urandom_range(0, 1) * 8191) : 13'($urandom_range(1, 4096));
    h = $urandom_range(0, 3) == 0 ? 13'($urandom) : 13'($urandom_range(1, 4096));
    load_config(m[0], m[1], m[2],
                camera ? {32'($signed($urandom_range(0, 20 << 16)) - (10 << 16)), 16'h0, 16'($urandom)}
                       : {$urandom, $urandom},
                camera ? {32'($urandom_range(0, 2 << 16)), $urandom} : {$urandom, $urandom},
                w, h);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) idle_on = ~idle_on;
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
    idle_on = 1'b1;
  endtask

  // output side: random stall per word, none while idle_on is low
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && !out_stall && idle_on) stall_left <= $urandom_range(0, 4);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", out_data);
      end else begin
        out_word_t exp_word;
        exp_word = pending_words.pop_front();
        if (out_data.visible !== exp_word.visible || out_data.screen_x !== exp_word.screen_x ||
            out_data.screen_y !== exp_word.screen_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp vis=%0d x=%0d y=%0d got vis=%0d x=%0d y=%0d",
                     exp_word.visible, exp_word.screen_x, exp_word.screen_y,
                     out_data.visible, out_data.screen_x, out_data.screen_y);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    proj_regs[0] = RST_X_COEFFS;
    proj_regs[1] = RST_Y_COEFFS;
    proj_regs[2] = RST_Z_COEFFS;
    proj_regs[3] = RST_OFFSET_XY;
    proj_regs[4] = RST_OFFSET_ZW;
    proj_regs[5] = 64'(RST_VIEW_W);
    proj_regs[6] = 64'(RST_VIEW_H);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_near_plane();
    test_viewport_extremes();
    for (int p = 0; p < 6; p++) test_random_phase(p % 3 != 2, 275);
    wait_idle();
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
